@@ rtl/proxy_arp_responder_top_macros.svh @@
// assertion helpers used by proxy_arp_responder_top
`ifndef PROXY_ARP_RESPONDER_TOP_MACROS_SVH
`define PROXY_ARP_RESPONDER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PAR_ASSERT_SAME(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PAR_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ant) |=> (cons)) else $error(msg);

`endif

@@ rtl/par_pkg.sv @@
`timescale 1ns / 1ps

package par_pkg;

    // item kinds carried in tuser
    localparam logic [1:0] ACT_FRAME = 2'd0;
    localparam logic [1:0] ACT_DEST  = 2'd1;
    localparam logic [1:0] ACT_SRC   = 2'd2;

    // frame layout
    localparam int          CAPTURE_BYTES = 42;
    localparam logic [5:0]  LAST_POS      = 6'(CAPTURE_BYTES - 1);
    localparam logic [15:0] ETYPE_ARP     = 16'h0806;
    localparam logic [15:0] OP_REQUEST    = 16'h0001;
    localparam logic [7:0]  OP_REPLY      = 8'h02;
    localparam logic [7:0]  BCAST         = 8'hff;

    // capture offsets
    localparam logic [5:0] POS_ETYPE_HI = 6'd12;
    localparam logic [5:0] POS_ETYPE_LO = 6'd13;
    localparam logic [5:0] POS_OP_HI    = 6'd20;
    localparam logic [5:0] POS_OP_LO    = 6'd21;
    localparam logic [5:0] POS_SIP_LO   = 6'd28;
    localparam logic [5:0] POS_SIP_HI   = 6'd31;
    localparam logic [5:0] POS_TIP_LO   = 6'd38;
    localparam logic [5:0] POS_TIP_HI   = 6'd41;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_REPLY
    } t_state;

    // reply frame byte at wire position pos
    function automatic logic [7:0] reply_byte(input logic [5:0]  pos,
                                              input logic [47:0] mac,
                                              input logic [31:0] tip,
                                              input logic [31:0] sip);
        logic [7:0] b;
        b = 8'h00;
        unique case (pos)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5: b = BCAST;
            6'd6,  6'd22: b = mac[47:40];
            6'd7,  6'd23: b = mac[39:32];
            6'd8,  6'd24: b = mac[31:24];
            6'd9,  6'd25: b = mac[23:16];
            6'd10, 6'd26: b = mac[15:8];
            6'd11, 6'd27: b = mac[7:0];
            6'd12: b = ETYPE_ARP[15:8];
            6'd13: b = ETYPE_ARP[7:0];
            6'd14: b = 8'h00;
            6'd15: b = 8'h01;
            6'd16: b = 8'h08;
            6'd17: b = 8'h00;
            6'd18: b = 8'h06;
            6'd19: b = 8'h04;
            6'd20: b = 8'h00;
            6'd21: b = OP_REPLY;
            6'd28: b = tip[31:24];
            6'd29: b = tip[23:16];
            6'd30: b = tip[15:8];
            6'd31: b = tip[7:0];
            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37: b = BCAST;
            6'd38: b = sip[31:24];
            6'd39: b = sip[23:16];
            6'd40: b = sip[15:8];
            6'd41: b = sip[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/proxy_arp_responder_top.sv @@
// Proxy ARP responder. Received frame bytes come in one item per cycle on the
// slave stream (tuser = 0) while the block is idle; tuser = 1 or 2 writes an
// entry of the destination or source IP access list and never disturbs a
// frame being captured. The first 42 bytes of a frame are captured. On the
// byte with tlast the block walks both access lists, which live in two RAMs
// of ACL_DEPTH words sharing one read address; the input is held off from
// then until the lookup ends or, with a reply, until the end of the reply. If
// the frame is an ARP request whose target IP hits the destination list or
// whose sender IP hits the source list, a 42-byte ARP reply (source MAC and
// sender MAC from own_mac, broadcast destination, IPs swapped) follows at one
// byte per cycle while the sink takes items. The list valid bits are
// flip-flops cleared by reset, so the block is usable right after reset.
// own_mac is written on the cfg channel; the user must write it only while
// the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "proxy_arp_responder_top_macros.svh"

module proxy_arp_responder_top
    import par_pkg::*;
#(
    parameter int ACL_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: own_mac
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // frame_byte[7:0], entry_index[11:8], entry_ip[43:12], entry_valid[44], zero[47:45]
    input  logic [47:0] i_s_tdata,
    input  logic        i_s_tlast,   // frame_last
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    // reply stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // reply_byte[7:0]
    output logic        o_m_tlast    // reply_last
);

    localparam int AW = (ACL_DEPTH > 1) ? $clog2(ACL_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ACL_DEPTH - 1);
    localparam logic [8:0] DEPTH_9 = 9'(ACL_DEPTH);

    t_state r_state, n_state;

    logic [47:0] r_own_mac;
    logic [5:0]  r_bpos;
    logic [15:0] r_frame_type;
    logic [15:0] r_arp_op;
    logic [31:0] r_sender_ip;
    logic [31:0] r_target_ip;
    logic        r_dest_vld [ACL_DEPTH];
    logic        r_src_vld  [ACL_DEPTH];
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_rd_addr;
    logic        r_rd_pend;
    logic        r_hit;
    logic [5:0]  r_pos;
    logic        r_out_valid;
    logic [7:0]  r_out_data;
    logic        r_out_last;

    logic [7:0]    w_byte;
    logic [3:0]    w_idx;
    logic [31:0]   w_ip;
    logic          w_vld_in;
    logic [8:0]    w_idx_ext;
    logic [AW-1:0] w_waddr;
    logic          w_idx_ok;
    logic          w_acc;
    logic          w_frame_acc;
    logic          w_dest_wr;
    logic          w_src_wr;
    logic [31:0]   w_dest_rdata;
    logic [31:0]   w_src_rdata;
    logic          w_match;
    logic          w_arp_ok;
    logic          w_hit;
    logic          w_in_ready;
    logic          w_rd_en;
    logic          w_load;
    logic          w_reply_end;
    logic          w_clear;

    // input field unpacking
    assign w_byte    = i_s_tdata[7:0];
    assign w_idx     = i_s_tdata[11:8];
    assign w_ip      = i_s_tdata[43:12];
    assign w_vld_in  = i_s_tdata[44];
    assign w_idx_ext = {5'b0, w_idx};
    assign w_waddr   = w_idx_ext[AW-1:0];
    assign w_idx_ok  = w_idx_ext < DEPTH_9;

    assign w_acc       = i_s_tvalid && w_in_ready;
    assign w_frame_acc = w_acc && (i_s_tuser == ACT_FRAME);
    assign w_dest_wr   = w_acc && (i_s_tuser == ACT_DEST) && w_idx_ok;
    assign w_src_wr    = w_acc && (i_s_tuser == ACT_SRC) && w_idx_ok;

    // access list address storage
    par_ram #(.WIDTH(32), .DEPTH(ACL_DEPTH), .AW(AW)) u_dest_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_dest_wr),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_ip),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_dest_rdata)
    );

    par_ram #(.WIDTH(32), .DEPTH(ACL_DEPTH), .AW(AW)) u_src_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_src_wr),
        .i_wr_addr (w_waddr),
        .i_wr_data (w_ip),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_src_rdata)
    );

    // compare the entry read last cycle
    assign w_match = r_rd_pend &&
                     ((r_dest_vld[r_rd_addr] && (w_dest_rdata == r_target_ip)) ||
                      (r_src_vld[r_rd_addr] && (w_src_rdata == r_sender_ip)));
    assign w_arp_ok = (r_frame_type == ETYPE_ARP) && (r_arp_op == OP_REQUEST);
    assign w_hit    = w_arp_ok && (r_hit || w_match);

    // control outputs
    always_comb begin
        w_in_ready  = (r_state == ST_IDLE);
        w_rd_en     = (r_state == ST_SEARCH);
        w_load      = (r_state == ST_REPLY) && (!r_out_valid || i_m_tready);
        w_reply_end = w_load && (r_pos == LAST_POS);
        w_clear     = ((r_state == ST_DECIDE) && !w_hit) || w_reply_end;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_frame_acc && i_s_tlast) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = w_hit ? ST_REPLY : ST_IDLE;
            end
            ST_REPLY: begin
                if (w_reply_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // own_mac register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac <= '0;
        end else if (i_cfg_valid) begin
            r_own_mac <= i_cfg_data;
        end
    end

    // frame capture, cleared once the frame has been handled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_bpos       <= '0;
            r_frame_type <= '0;
            r_arp_op     <= '0;
            r_sender_ip  <= '0;
            r_target_ip  <= '0;
        end else if (w_frame_acc && (r_bpos < LAST_POS + 6'd1)) begin
            r_bpos <= r_bpos + 6'd1;
            if (r_bpos == POS_ETYPE_HI || r_bpos == POS_ETYPE_LO) begin
                r_frame_type <= {r_frame_type[7:0], w_byte};
            end else if (r_bpos == POS_OP_HI || r_bpos == POS_OP_LO) begin
                r_arp_op <= {r_arp_op[7:0], w_byte};
            end else if (r_bpos >= POS_SIP_LO && r_bpos <= POS_SIP_HI) begin
                r_sender_ip <= {r_sender_ip[23:0], w_byte};
            end else if (r_bpos >= POS_TIP_LO && r_bpos <= POS_TIP_HI) begin
                r_target_ip <= {r_target_ip[23:0], w_byte};
            end
        end
    end

    // list valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACL_DEPTH; i++) begin
                r_dest_vld[i] <= 1'b0;
                r_src_vld[i]  <= 1'b0;
            end
        end else begin
            if (w_dest_wr) begin
                r_dest_vld[w_waddr] <= w_vld_in;
            end
            if (w_src_wr) begin
                r_src_vld[w_waddr] <= w_vld_in;
            end
        end
    end

    // list sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_rd_pend <= w_rd_en;
            if (w_frame_acc && i_s_tlast) begin
                r_addr <= '0;
                r_hit  <= 1'b0;
            end else begin
                if (w_rd_en && r_addr != LAST_ADDR) begin
                    r_addr <= r_addr + AW'(1);
                end
                r_hit <= r_hit || w_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
    end

    // reply position counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (r_state == ST_DECIDE) begin
            r_pos <= '0;
        end else if (w_load) begin
            r_pos <= r_pos + 6'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= reply_byte(r_pos, r_own_mac, r_target_ip, r_sender_ip);
            r_out_last <= (r_pos == LAST_POS);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = w_in_ready;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign o_m_tlast   = r_out_last;

    // checks
    `PAR_ASSERT_NEXT(a_reply_end_idle, w_reply_end, r_state == ST_IDLE, "reply did not end in idle")
    `PAR_ASSERT_NEXT(a_reply_starts_zero, r_state == ST_DECIDE && w_hit, r_pos == 6'd0 && r_state == ST_REPLY, "reply did not start at byte zero")
    `PAR_ASSERT_SAME(a_read_after_search, r_rd_pend, $past(r_state) == ST_SEARCH, "list read data without a sweep")
    `PAR_ASSERT_NEXT(a_capture_cleared, w_clear, r_bpos == 6'd0 && r_frame_type == 16'h0000 && r_target_ip == 32'h0, "frame capture not cleared")

endmodule

@@ rtl/par_ram.sv @@
`timescale 1ns / 1ps

module par_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import par_pkg::*;

    localparam int          ACL_SLOTS     = 16;
    // lookup plus decision, with margin, after the last reply byte
    localparam int          SETTLE_CYCLES = 2 * ACL_SLOTS + 8;
    localparam int          RANDOM_ITEMS  = 160;
    localparam int          SINK_HOLD     = 400;
    localparam longint      LIMIT_NS      = 10_000_000;
    // unused item kind, ignored by the block
    localparam logic [1:0]  ACT_NONE      = 2'd3;
    // reply bytes 12..21: ethertype, hw type, protocol, lengths, opcode
    localparam logic [79:0] REPLY_HDR     = {ETYPE_ARP, 16'h0001, 16'h0800, 8'h06, 8'h04,
                                             8'h00, OP_REPLY};
    localparam logic [31:0] IP_A          = 32'h8000_0001;
    localparam logic [31:0] IP_B          = 32'hc0a8_0101;
    localparam logic [31:0] IP_C          = 32'h0a00_0005;
    localparam logic [31:0] IP_ALL_ONES   = 32'hffff_ffff;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  frame_byte;
        logic        frame_last;
        logic [3:0]  entry_index;
        logic [31:0] entry_ip;
        logic        entry_valid;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
    } t_reply_item;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SLOW,
        SINK_BEAT
    } t_sink_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_data  = '0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata   = '0;
    logic        i_s_tlast   = 1'b0;
    logic [1:0]  i_s_tuser   = ACT_FRAME;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic        o_m_tlast;

    // stimulus and expectation stores
    t_in_item    pending_items[$];
    t_reply_item reply_due[$];
    logic [31:0] known_ips[$];
    int          items_queued  = 0;
    int          mismatch_count = 0;
    bit          item_taken    = 1'b0;
    int          sink_hold_cycles = 0;

    // shadow of the block state
    logic [47:0] mac_model = '0;
    int          cap_pos   = 0;
    logic [15:0] cap_etype = '0;
    logic [15:0] cap_op    = '0;
    logic [31:0] cap_sip   = '0;
    logic [31:0] cap_tip   = '0;
    logic        dest_on   [ACL_SLOTS] = '{default: 1'b0};
    logic [31:0] dest_addr [ACL_SLOTS] = '{default: '0};
    logic        src_on    [ACL_SLOTS] = '{default: 1'b0};
    logic [31:0] src_entry_ip [ACL_SLOTS] = '{default: '0};

    proxy_arp_responder_top #(
        .ACL_DEPTH(ACL_SLOTS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // reply frame byte at wire position p
    function automatic logic [7:0] arp_reply_at(input int p);
        if (p < 6 || (p >= 32 && p < 38)) return BCAST;
        if (p < 12) return mac_model[47 - 8 * (p - 6) -: 8];
        if (p < 22) return REPLY_HDR[79 - 8 * (p - 12) -: 8];
        if (p < 28) return mac_model[47 - 8 * (p - 22) -: 8];
        if (p < 32) return cap_tip[31 - 8 * (p - 28) -: 8];
        return cap_sip[31 - 8 * (p - 38) -: 8];
    endfunction

    // update the shadow state with one accepted item, queue any reply
    task automatic predict_arp_reply(input t_in_item it);
        logic        dest_hit;
        logic        src_hit;
        t_reply_item ri;
        dest_hit = 1'b0;
        src_hit  = 1'b0;
        case (it.action)
            ACT_DEST: begin
                dest_on[it.entry_index]   = it.entry_valid;
                dest_addr[it.entry_index] = it.entry_ip;
            end
            ACT_SRC: begin
                src_on[it.entry_index]       = it.entry_valid;
                src_entry_ip[it.entry_index] = it.entry_ip;
            end
            ACT_FRAME: begin
                // capture only the first 42 bytes
                if (cap_pos < CAPTURE_BYTES) begin
                    if (cap_pos == POS_ETYPE_HI || cap_pos == POS_ETYPE_LO)
                        cap_etype = {cap_etype[7:0], it.frame_byte};
                    else if (cap_pos == POS_OP_HI || cap_pos == POS_OP_LO)
                        cap_op = {cap_op[7:0], it.frame_byte};
                    else if (cap_pos >= POS_SIP_LO && cap_pos <= POS_SIP_HI)
                        cap_sip = {cap_sip[23:0], it.frame_byte};
                    else if (cap_pos >= POS_TIP_LO && cap_pos <= POS_TIP_HI)
                        cap_tip = {cap_tip[23:0], it.frame_byte};
                    cap_pos++;
                end
                if (it.frame_last) begin
                    for (int i = 0; i < ACL_SLOTS; i++) begin
                        if (dest_on[i] && dest_addr[i] == cap_tip) dest_hit = 1'b1;
                        if (src_on[i] && src_entry_ip[i] == cap_sip) src_hit = 1'b1;
                    end
                    if (cap_etype == ETYPE_ARP && cap_op == OP_REQUEST && (dest_hit || src_hit)) begin
                        for (int p = 0; p < CAPTURE_BYTES; p++) begin
                            ri.reply_byte = arp_reply_at(p);
                            ri.reply_last = (p == CAPTURE_BYTES - 1);
                            reply_due.push_back(ri);
                        end
                    end
                    cap_pos   = 0;
                    cap_etype = '0;
                    cap_op    = '0;
                    cap_sip   = '0;
                    cap_tip   = '0;
                end
            end
            default: ;
        endcase
    endtask

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // input driver: bursts of items with random gaps, holds until taken
    int burst_left = 1;
    int gap_left   = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {3'b000, pending_items[0].entry_valid, pending_items[0].entry_ip,
                               pending_items[0].entry_index, pending_items[0].frame_byte};
                i_s_tlast  <= pending_items[0].frame_last;
                i_s_tuser  <= pending_items[0].action;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 48);
                    case ($urandom_range(0, 19))
                        0:       gap_left = $urandom_range(20, 40);
                        1, 2, 3: gap_left = $urandom_range(4, 12);
                        default: gap_left = $urandom_range(0, 3);
                    endcase
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // reply sink: changing stall patterns, plus a long hold-off on request
    t_sink_mode sink_mode = SINK_OPEN;
    int         sink_mode_left = 0;
    int         sink_tick = 0;
    always @(negedge i_clk) begin
        sink_tick++;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (sink_hold_cycles > 0) begin
            sink_hold_cycles--;
            i_m_tready <= 1'b0;
        end else begin
            if (sink_mode_left == 0) begin
                sink_mode      = t_sink_mode'($urandom_range(0, 3));
                sink_mode_left = $urandom_range(10, 120);
            end else begin
                sink_mode_left--;
            end
            case (sink_mode)
                SINK_OPEN: i_m_tready <= 1'b1;
                SINK_COIN: i_m_tready <= 1'($urandom_range(0, 1));
                SINK_SLOW: i_m_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_tready <= (sink_tick % 3 != 0);
            endcase
        end
    end

    // monitor: predict on accepted input items, check accepted reply items
    t_reply_item due;
    always @(posedge i_clk) begin
        item_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                item_taken = 1'b1;
                predict_arp_reply(pending_items.pop_front());
            end
            if (o_m_tvalid && i_m_tready) begin
                if (reply_due.size() == 0) begin
                    $error("unexpected reply item: reply_byte %02h, reply_last %0b",
                           o_m_tdata, o_m_tlast);
                    mismatch_count++;
                end else begin
                    due = reply_due.pop_front();
                    if (o_m_tdata !== due.reply_byte) begin
                        $error("reply_byte: expected %02h, actual %02h", due.reply_byte, o_m_tdata);
                        mismatch_count++;
                    end
                    if (o_m_tlast !== due.reply_last) begin
                        $error("reply_last: expected %0b, actual %0b", due.reply_last, o_m_tlast);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic queue_item(input logic [1:0] act, input logic [7:0] fb, input logic fl,
                              input logic [3:0] idx, input logic [31:0] ip, input logic ev);
        t_in_item it;
        it.action      = act;
        it.frame_byte  = fb;
        it.frame_last  = fl;
        it.entry_index = idx;
        it.entry_ip    = ip;
        it.entry_valid = ev;
        pending_items.push_back(it);
        if (act != ACT_NONE) items_queued++;
    endtask

    // table write with random frame fields
    task automatic queue_acl_write(input logic [1:0] act, input logic [3:0] idx,
                                   input logic [31:0] ip, input logic ev);
        queue_item(act, 8'($urandom), 1'($urandom), idx, ip, ev);
        if (ev) known_ips.push_back(ip);
    endtask

    // frame of len bytes with the arp fields placed, other bytes random
    task automatic queue_frame(input logic [15:0] etype, input logic [15:0] op,
                               input logic [31:0] sip, input logic [31:0] tip,
                               input int len, input bit noisy);
        logic [7:0] b;
        for (int k = 0; k < len; k++) begin
            b = 8'($urandom);
            if (k == 12 || k == 13) b = etype[8 * (13 - k) +: 8];
            else if (k == 20 || k == 21) b = op[8 * (21 - k) +: 8];
            else if (k >= 28 && k < 32) b = sip[8 * (31 - k) +: 8];
            else if (k >= 38 && k < 42) b = tip[8 * (41 - k) +: 8];
            queue_item(ACT_FRAME, b, k == len - 1, 4'($urandom), $urandom, 1'($urandom));
            // ignored items and table writes inside a frame
            if (noisy && k < len - 1) begin
                if ($urandom_range(0, 5) == 0)
                    queue_item(ACT_NONE, 8'($urandom), 1'($urandom), 4'($urandom), $urandom,
                               1'($urandom));
                if ($urandom_range(0, 15) == 0)
                    queue_acl_write($urandom_range(0, 1) ? ACT_DEST : ACT_SRC, 4'($urandom),
                                    $urandom, 1'($urandom));
            end
        end
    endtask

    function automatic logic [31:0] pick_ip();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return IP_ALL_ONES;
            2, 3: return $urandom;
            default: return known_ips[$urandom_range(0, known_ips.size() - 1)];
        endcase
    endfunction

    task automatic queue_random_sequence();
        int          pick;
        int          len;
        logic [15:0] etype;
        logic [15:0] op;
        pick  = $urandom_range(0, 99);
        etype = ETYPE_ARP;
        op    = OP_REQUEST;
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(CAPTURE_BYTES + 1, 64)
                                            : CAPTURE_BYTES;
        if (pick < 14) begin
            queue_acl_write($urandom_range(0, 1) ? ACT_DEST : ACT_SRC, 4'($urandom),
                            $urandom_range(0, 1) ? $urandom : pick_ip(),
                            $urandom_range(0, 4) != 0);
        end else if (pick < 18) begin
            queue_item(ACT_NONE, 8'($urandom), 1'($urandom), 4'($urandom), $urandom,
                       1'($urandom));
        end else if (pick < 78) begin
            queue_frame(etype, op, pick_ip(), pick_ip(), len, $urandom_range(0, 4) == 0);
        end else begin
            // broken requests
            case ($urandom_range(0, 3))
                0: etype = ETYPE_ARP ^ (16'h1 << $urandom_range(0, 15));
                1: op = OP_REQUEST ^ (16'h1 << $urandom_range(0, 15));
                2: len = $urandom_range(1, CAPTURE_BYTES - 1);
                default: begin
                    etype = 16'($urandom);
                    op    = 16'($urandom);
                end
            endcase
            queue_frame(etype, op, pick_ip(), pick_ip(), len, $urandom_range(0, 2) == 0);
        end
    endtask

    // own_mac write on the cfg channel, block idle
    task automatic write_own_mac(input logic [47:0] mac);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mac;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mac_model = mac;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until every item is taken and every reply byte has come
    task automatic wait_drained();
        while (pending_items.size() > 0 || reply_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // stimulus sequence
    int phase = 0;
    int random_start;
    int batch_end;
    initial begin
        known_ips = '{IP_A, IP_B, IP_C, 32'h0, IP_ALL_ONES};
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_own_mac(48'hffff_ffff_ffff);
        // lists empty after reset: no reply
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        queue_acl_write(ACT_DEST, 4'd0, IP_ALL_ONES, 1'b1);
        queue_acl_write(ACT_SRC, 4'd15, 32'h0, 1'b1);
        queue_acl_write(ACT_DEST, 4'd7, IP_B, 1'b1);
        queue_acl_write(ACT_DEST, 4'd8, IP_B, 1'b1);
        queue_acl_write(ACT_SRC, 4'd3, IP_C, 1'b0);
        // target hit, then sender on a cleared slot
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_C, IP_A, CAPTURE_BYTES, 1'b0);
        // short frame: ips read as zero, hits the zero source entry
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_A, 22, 1'b0);
        // too short for the ethertype, and a single byte frame
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, 13, 1'b0);
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, 1, 1'b0);
        // long frame, all-ones target
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_ALL_ONES, 60, 1'b0);
        // wrong ethertype, reply opcode, other opcode
        queue_frame(16'h0800, OP_REQUEST, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        queue_frame(ETYPE_ARP, 16'h0002, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        queue_frame(ETYPE_ARP, 16'h0101, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        // source hit once the slot is valid, with noise items
        queue_acl_write(ACT_SRC, 4'd3, IP_C, 1'b1);
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_C, IP_A, CAPTURE_BYTES, 1'b1);
        // duplicate entry keeps the match, then none left
        queue_acl_write(ACT_DEST, 4'd7, IP_B, 1'b0);
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        queue_acl_write(ACT_DEST, 4'd8, IP_B, 1'b0);
        queue_frame(ETYPE_ARP, OP_REQUEST, IP_A, IP_B, CAPTURE_BYTES, 1'b0);
        wait_drained();

        // sink holds off while requests keep coming
        write_own_mac(48'h0);
        sink_hold_cycles = SINK_HOLD;
        repeat (3) queue_frame(ETYPE_ARP, OP_REQUEST, IP_C, $urandom, CAPTURE_BYTES, 1'b0);
        wait_drained();

        // random phases, each under its own own_mac
        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            case (phase % 4)
                0: write_own_mac(48'h0123_4567_89ab);
                1: write_own_mac(48'hffff_ffff_ffff);
                2: write_own_mac(48'h0);
                default: write_own_mac(48'({$urandom, $urandom}));
            endcase
            phase++;
            batch_end = items_queued + 40;
            while (items_queued < batch_end) queue_random_sequence();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/par_pkg.sv
rtl/par_ram.sv
rtl/proxy_arp_responder_top.sv
tb/testbench.sv
